// File: hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

	localparam int ADDR_W = 32;
	localparam int EB_W   = 17;
	localparam int SIZE_W = 18;
	localparam int CNT9_W = 9;
	localparam int OUT_W  = 48;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_ELEM = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NULL     = 3'd2,
		ST_OUTSIDE  = 3'd3,
		ST_MISALIGN = 3'd4,
		ST_FREED    = 3'd5
	} status_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		logic    alloc_commit;
		logic    free_commit;
		logic    set_res;
		status_t code;
		logic    emit;
	} dp_cmd_t;

	typedef struct packed {
		logic op;
		logic empty;
		logic null_addr;
		logic outside;
		logic div_done;
		logic misalign;
		logic taken;
		logic out_free;
	} dp_sts_t;

	// zero is taken as one, then rounded up to a multiple of eight
	function automatic logic [SIZE_W-1:0] pad_size(input logic [EB_W-1:0] eb);
		logic [SIZE_W-1:0] s;
		logic [SIZE_W-1:0] t;
		s = (eb == '0) ? SIZE_W'(1) : SIZE_W'(eb);
		t = s + SIZE_W'(7);
		return {t[SIZE_W-1:3], 3'b000};
	endfunction

endpackage

// File: hw/rtl/fixed_buffer_pool_allocator_top.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: address; s_tuser: op
// m_        out  m_tvalid/m_tready    m_tdata: status, buffer_address, free_buffers
// cfg_      in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// an allocate goes through S_CHECK, S_ALLOC_RD and S_DONE; the link memory read is registered,
// and the index multiply is registered ahead of it
// a free runs the 32-step serial divider for the offset
// one request at a time; the next is taken once the result sits in the output register
// reset is ready at once: untouched entries are covered by a fill mark, no clearing pass
// a stalled result holds the controller in its final state
module fixed_buffer_pool_allocator_top
	import fbpa_pkg::*;
#(
	parameter int POOL_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ADDR_W-1:0] s_tdata,   // [31:0] address
	input  logic [0:0]        s_tuser,   // [0] op
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [2:0] status, [34:3] buffer_address,
	                                     // [43:35] free_buffers, [47:44] zero
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbpa_datapath #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_op      (s_tuser[0]),
		.req_address (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

// File: hw/rtl/fbpa_ram.sv
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/fbpa_div.sv
module fbpa_div
	import fbpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [ADDR_W-1:0] quotient,
	output logic [SIZE_W-1:0] remainder
);

	localparam int STEP_W = $clog2(ADDR_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SIZE_W-1:0] rem_q;
	logic [ADDR_W-1:0] quo_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic              ge;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, quo_q[ADDR_W-1]};
		ge    = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(ADDR_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			quo_q <= {quo_q[ADDR_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/fbpa_datapath.sv
module fbpa_datapath
	import fbpa_pkg::*;
#(
	parameter int POOL_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              req_op,
	input  logic [ADDR_W-1:0] req_address,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata
);

	localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
	localparam int PROD_W = SIZE_W + IDX_W;
	localparam int EXT_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
	localparam int CE_W   = (CNT_W > CNT9_W) ? CNT_W : CNT9_W;

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [ADDR_W-1:0] offset_q;
	logic [PROD_W-1:0] span_q;
	logic [PROD_W-1:0] prod_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_q;

	logic              div_done;
	logic [ADDR_W-1:0] quotient;
	logic [SIZE_W-1:0] remainder;
	logic [IDX_W-1:0]  quot_idx;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [IDX_W:0]    ram_wdata;
	logic [IDX_W:0]    ram_rdata;

	logic              fresh_pop;
	logic [IDX_W-1:0]  next_head;
	logic [EXT_W-1:0]  sum_ext;
	logic [CE_W-1:0]   count_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= SIZE_W'(8);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_BASE) begin
				base_q <= cfg_data;
			end else begin
				size_q <= pad_size(cfg_data[EB_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_op;
			addr_q <= req_address;
		end
		offset_q <= addr_q - base_q;
		span_q   <= PROD_W'(size_q) * PROD_W'(POOL_DEPTH - 1);
		prod_q   <= PROD_W'(head_q) * PROD_W'(size_q);
	end

	fbpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (offset_q),
		.divisor   (size_q),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign quot_idx = quotient[IDX_W-1:0];

	// entry word: allocated bit over the free-list link
	// entries at or above the fresh mark were never handed out
	always_comb begin
		fresh_pop = (CNT_W'(head_q) == fresh_q);
		next_head = fresh_pop ? IDX_W'(CNT_W'(head_q) + CNT_W'(1)) : ram_rdata[IDX_W-1:0];
		ram_addr  = (op_q == OP_FREE) ? quot_idx : head_q;
		ram_we    = cmd.alloc_commit | cmd.free_commit;
		ram_wdata = cmd.free_commit ? {1'b0, head_q} : {1'b1, ram_rdata[IDX_W-1:0]};
		sum_ext   = EXT_W'(base_q) + EXT_W'(prod_q);
		count_ext = CE_W'(count_q);
	end

	fbpa_ram #(
		.WIDTH (IDX_W + 1),
		.DEPTH (POOL_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= CNT_W'(POOL_DEPTH);
			fresh_q <= '0;
		end else if (cmd.alloc_commit) begin
			head_q  <= next_head;
			count_q <= count_q - CNT_W'(1);
			if (fresh_pop) begin
				fresh_q <= fresh_q + CNT_W'(1);
			end
		end else if (cmd.free_commit) begin
			head_q  <= quot_idx;
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.code;
			res_addr_q   <= cmd.alloc_commit ? sum_ext[ADDR_W-1:0] : '0;
		end
		if (cmd.emit) begin
			out_q <= {{(OUT_W - CNT9_W - ADDR_W - 3){1'b0}}, count_ext[CNT9_W-1:0],
				res_addr_q, res_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.empty     = (count_q == '0);
		sts.null_addr = (addr_q == '0);
		sts.outside   = (EXT_W'(offset_q) > EXT_W'(span_q));
		sts.div_done  = div_done;
		sts.misalign  = (remainder != '0);
		sts.taken     = (CNT_W'(quot_idx) < fresh_q) && ram_rdata[IDX_W];
		sts.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// File: hw/rtl/fbpa_ctrl.sv
module fbpa_ctrl
	import fbpa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_CHECK    = 8'b0000_0010,
		S_ALLOC_RD = 8'b0000_0100,
		S_FREE_CHK = 8'b0000_1000,
		S_DIV      = 8'b0001_0000,
		S_FREE_RD  = 8'b0010_0000,
		S_FREE_WR  = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.code = ST_OK;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.op == OP_ALLOC) begin
					if (sts.empty) begin
						cmd.set_res = 1'b1;
						cmd.code    = ST_EMPTY;
						state_d     = S_DONE;
					end else begin
						state_d = S_ALLOC_RD;
					end
				end else if (sts.null_addr) begin
					cmd.set_res = 1'b1;
					cmd.code    = ST_NULL;
					state_d     = S_DONE;
				end else begin
					state_d = S_FREE_CHK;
				end
			end
			S_ALLOC_RD: begin
				cmd.alloc_commit = 1'b1;
				cmd.set_res      = 1'b1;
				cmd.code         = ST_OK;
				state_d          = S_DONE;
			end
			S_FREE_CHK: begin
				if (sts.outside) begin
					cmd.set_res = 1'b1;
					cmd.code    = ST_OUTSIDE;
					state_d     = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_FREE_RD;
				end
			end
			S_FREE_RD: begin
				// entry read is issued here, data arrives next cycle
				if (sts.misalign) begin
					cmd.set_res = 1'b1;
					cmd.code    = ST_MISALIGN;
					state_d     = S_DONE;
				end else begin
					state_d = S_FREE_WR;
				end
			end
			S_FREE_WR: begin
				cmd.set_res = 1'b1;
				if (sts.taken) begin
					cmd.free_commit = 1'b1;
					cmd.code        = ST_OK;
				end else begin
					cmd.code = ST_FREED;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
